@@ hdl/gzp_pkg.sv @@
// Shared types, phase codes, error codes and helper functions for the
// gzip header parser. No dependencies.

package gzp_pkg;

   localparam int COUNT_BITS_DEF = 32;
   localparam int PHASE_BITS     = 5;
   localparam int ERR_BITS       = 5;
   localparam int HDR_LEN_BITS   = 32;

   // parse phases
   localparam logic [PHASE_BITS-1:0] PH_MAGIC1  = 5'd0;
   localparam logic [PHASE_BITS-1:0] PH_MAGIC2  = 5'd1;
   localparam logic [PHASE_BITS-1:0] PH_METHOD  = 5'd2;
   localparam logic [PHASE_BITS-1:0] PH_FLAGS   = 5'd3;
   localparam logic [PHASE_BITS-1:0] PH_MTIME1  = 5'd4;
   localparam logic [PHASE_BITS-1:0] PH_MTIME2  = 5'd5;
   localparam logic [PHASE_BITS-1:0] PH_MTIME3  = 5'd6;
   localparam logic [PHASE_BITS-1:0] PH_MTIME4  = 5'd7;
   localparam logic [PHASE_BITS-1:0] PH_XFL     = 5'd8;
   localparam logic [PHASE_BITS-1:0] PH_OS      = 5'd9;
   localparam logic [PHASE_BITS-1:0] PH_XLEN1   = 5'd10;
   localparam logic [PHASE_BITS-1:0] PH_XLEN2   = 5'd11;
   localparam logic [PHASE_BITS-1:0] PH_XDATA   = 5'd12;
   localparam logic [PHASE_BITS-1:0] PH_NAME    = 5'd13;
   localparam logic [PHASE_BITS-1:0] PH_COMMENT = 5'd14;
   localparam logic [PHASE_BITS-1:0] PH_CRC1    = 5'd15;
   localparam logic [PHASE_BITS-1:0] PH_CRC2    = 5'd16;
   localparam logic [PHASE_BITS-1:0] PH_DONE    = 5'd17;

   // error codes, in header order
   localparam logic [ERR_BITS-1:0] ERR_NONE        = 5'd0;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MAGIC1  = 5'd1;
   localparam logic [ERR_BITS-1:0] ERR_BAD_MAGIC1  = 5'd2;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MAGIC2  = 5'd3;
   localparam logic [ERR_BITS-1:0] ERR_BAD_MAGIC2  = 5'd4;
   localparam logic [ERR_BITS-1:0] ERR_EOF_METHOD  = 5'd5;
   localparam logic [ERR_BITS-1:0] ERR_BAD_METHOD  = 5'd6;
   localparam logic [ERR_BITS-1:0] ERR_EOF_FLAGS   = 5'd7;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MTIME1  = 5'd8;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MTIME2  = 5'd9;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MTIME3  = 5'd10;
   localparam logic [ERR_BITS-1:0] ERR_EOF_MTIME4  = 5'd11;
   localparam logic [ERR_BITS-1:0] ERR_EOF_XFL     = 5'd12;
   localparam logic [ERR_BITS-1:0] ERR_EOF_OS      = 5'd13;
   localparam logic [ERR_BITS-1:0] ERR_EOF_XLEN1   = 5'd14;
   localparam logic [ERR_BITS-1:0] ERR_EOF_XLEN2   = 5'd15;
   localparam logic [ERR_BITS-1:0] ERR_EOF_XDATA   = 5'd16;
   localparam logic [ERR_BITS-1:0] ERR_EOF_NAME    = 5'd17;
   localparam logic [ERR_BITS-1:0] ERR_EOF_COMMENT = 5'd18;
   localparam logic [ERR_BITS-1:0] ERR_EOF_CRC1    = 5'd19;
   localparam logic [ERR_BITS-1:0] ERR_EOF_CRC2    = 5'd20;
   localparam logic [ERR_BITS-1:0] ERR_MAX         = ERR_EOF_CRC2;

   localparam logic [7:0] MAGIC1_BYTE  = 8'h1F;
   localparam logic [7:0] MAGIC2_BYTE  = 8'h8B;
   localparam logic [7:0] METHOD_BYTE  = 8'd8;

   // flag bits
   localparam int FLG_HCRC    = 1;
   localparam int FLG_EXTRA   = 2;
   localparam int FLG_NAME    = 3;
   localparam int FLG_COMMENT = 4;

   localparam int MIN_HDR_LEN = 10;

   typedef struct packed {
      logic       req_type;
      logic [7:0] data_byte;
      logic       first_of_file;
   } gzp_item_type;

   typedef struct packed {
      logic                    is_compressed;
      logic [7:0]              flags_byte;
      logic [HDR_LEN_BITS-1:0] header_length;
      logic [ERR_BITS-1:0]     error_code;
   } gzp_result_type;

   // error for an end-of-file mark seen in a given phase
   function automatic logic [ERR_BITS-1:0] eof_code(input logic [PHASE_BITS-1:0] phase);
      logic [ERR_BITS-1:0] code;
      unique case (phase)
         PH_MAGIC1:  code = ERR_EOF_MAGIC1;
         PH_MAGIC2:  code = ERR_EOF_MAGIC2;
         PH_METHOD:  code = ERR_EOF_METHOD;
         PH_FLAGS:   code = ERR_EOF_FLAGS;
         PH_MTIME1:  code = ERR_EOF_MTIME1;
         PH_MTIME2:  code = ERR_EOF_MTIME2;
         PH_MTIME3:  code = ERR_EOF_MTIME3;
         PH_MTIME4:  code = ERR_EOF_MTIME4;
         PH_XFL:     code = ERR_EOF_XFL;
         PH_OS:      code = ERR_EOF_OS;
         PH_XLEN1:   code = ERR_EOF_XLEN1;
         PH_XLEN2:   code = ERR_EOF_XLEN2;
         PH_XDATA:   code = ERR_EOF_XDATA;
         PH_NAME:    code = ERR_EOF_NAME;
         PH_COMMENT: code = ERR_EOF_COMMENT;
         PH_CRC1:    code = ERR_EOF_CRC1;
         PH_CRC2:    code = ERR_EOF_CRC2;
         default:    code = ERR_NONE;
      endcase
      return code;
   endfunction

   // next optional section enabled by the flags, searching from a phase on
   function automatic logic [PHASE_BITS-1:0] next_section(
      input logic [PHASE_BITS-1:0] from,
      input logic [7:0]            flags
   );
      logic [PHASE_BITS-1:0] nxt;
      priority if (from <= PH_XLEN1 && flags[FLG_EXTRA])     nxt = PH_XLEN1;
      else if (from <= PH_NAME && flags[FLG_NAME])           nxt = PH_NAME;
      else if (from <= PH_COMMENT && flags[FLG_COMMENT])     nxt = PH_COMMENT;
      else if (from <= PH_CRC1 && flags[FLG_HCRC])           nxt = PH_CRC1;
      else                                                   nxt = PH_DONE;
      return nxt;
   endfunction

endpackage

@@ hdl/gzp_req_if.sv @@
// Input channel interface: valid/ready handshake carrying one file byte
// or end-of-file mark. No dependencies.

interface gzp_req_if;
   logic       valid;
   logic       ready;
   logic       req_type;
   logic [7:0] data_byte;
   logic       first_of_file;

   modport source (output valid, req_type, data_byte, first_of_file, input ready);
   modport sink   (input valid, req_type, data_byte, first_of_file, output ready);
endinterface

@@ hdl/gzp_rsp_if.sv @@
// Result channel interface: valid/ready handshake carrying one header
// parse result. No dependencies.

interface gzp_rsp_if;
   logic        valid;
   logic        ready;
   logic        is_compressed;
   logic [7:0]  flags_byte;
   logic [31:0] header_length;
   logic [4:0]  error_code;

   modport source (output valid, is_compressed, flags_byte, header_length, error_code,
                   input ready);
   modport sink   (input valid, is_compressed, flags_byte, header_length, error_code,
                   output ready);
endinterface

@@ hdl/gzp_core.sv @@
// Header parse state and per-byte next-state logic.
// Depends on gzp_pkg.

module gzp_core #(
   parameter int COUNT_BITS = gzp_pkg::COUNT_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_valid,
   input  gzp_pkg::gzp_item_type   item,
   output logic                    res_valid,
   output gzp_pkg::gzp_result_type res
);
   import gzp_pkg::*;

   localparam logic [COUNT_BITS-1:0] CountMax = '1;

   logic [PHASE_BITS-1:0] phase_ff, phase_in, phase_cur, nxt;
   logic [7:0]            flags_ff, flags_in, flags_cur;
   logic [15:0]           xleft_ff, xleft_in, xleft_cur, xleft_dec;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_cur;
   logic [63:0]           count_wide;

   // first-of-file restarts from a clean state before the byte is parsed
   assign phase_cur = item.first_of_file ? PH_MAGIC1 : phase_ff;
   assign flags_cur = item.first_of_file ? 8'd0 : flags_ff;
   assign xleft_cur = item.first_of_file ? 16'd0 : xleft_ff;
   assign count_cur = item.first_of_file ? '0 : count_ff;
   assign xleft_dec = xleft_cur - 16'd1;
   assign count_wide = 64'(count_in);

   always_comb begin
      phase_in  = phase_cur;
      flags_in  = flags_cur;
      xleft_in  = xleft_cur;
      count_in  = count_cur;
      nxt       = phase_cur + 5'd1;
      res_valid = 1'b0;
      res.is_compressed = 1'b0;
      res.header_length = '0;
      res.error_code    = ERR_NONE;
      if (phase_cur < PH_DONE) begin
         if (item.req_type) begin
            res_valid      = 1'b1;
            res.error_code = eof_code(phase_cur);
            phase_in       = PH_DONE;
         end else begin
            if (count_cur != CountMax) begin
               count_in = count_cur + 1'b1;
            end
            unique case (phase_cur)
               PH_MAGIC1: begin
                  if (item.data_byte != MAGIC1_BYTE) begin
                     res_valid      = 1'b1;
                     res.error_code = ERR_BAD_MAGIC1;
                  end
               end
               PH_MAGIC2: begin
                  if (item.data_byte != MAGIC2_BYTE) begin
                     res_valid      = 1'b1;
                     res.error_code = ERR_BAD_MAGIC2;
                  end
               end
               PH_METHOD: begin
                  if (item.data_byte != METHOD_BYTE) begin
                     res_valid      = 1'b1;
                     res.error_code = ERR_BAD_METHOD;
                  end
               end
               PH_FLAGS: flags_in = item.data_byte;
               PH_MTIME1, PH_MTIME2, PH_MTIME3, PH_MTIME4, PH_XFL, PH_CRC1: ;
               PH_OS:    nxt = next_section(PH_XLEN1, flags_cur);
               PH_XLEN1: xleft_in = {8'd0, item.data_byte};
               PH_XLEN2: begin
                  xleft_in = {item.data_byte, xleft_cur[7:0]};
                  nxt = (xleft_in != 16'd0) ? PH_XDATA : next_section(PH_NAME, flags_cur);
               end
               PH_XDATA: begin
                  xleft_in = xleft_dec;
                  nxt = (xleft_dec != 16'd0) ? PH_XDATA : next_section(PH_NAME, flags_cur);
               end
               PH_NAME: begin
                  nxt = (item.data_byte != 8'd0) ? PH_NAME
                                                 : next_section(PH_COMMENT, flags_cur);
               end
               PH_COMMENT: begin
                  nxt = (item.data_byte != 8'd0) ? PH_COMMENT
                                                 : next_section(PH_CRC1, flags_cur);
               end
               PH_CRC2:  nxt = PH_DONE;
               default:  ;
            endcase
            if (res_valid) begin
               phase_in = PH_DONE;
            end else if (nxt >= PH_DONE) begin
               res_valid         = 1'b1;
               res.is_compressed = 1'b1;
               res.header_length = (|count_wide[63:HDR_LEN_BITS]) ? '1
                                   : count_wide[HDR_LEN_BITS-1:0];
               phase_in          = PH_DONE;
            end else begin
               phase_in = nxt;
            end
         end
      end
      res.flags_byte = flags_in;
      res_valid      = res_valid & step_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_MAGIC1;
         flags_ff <= 8'd0;
         xleft_ff <= 16'd0;
         count_ff <= '0;
      end else if (step_valid) begin
         phase_ff <= phase_in;
         flags_ff <= flags_in;
         xleft_ff <= xleft_in;
         count_ff <= count_in;
      end
   end

endmodule

@@ hdl/gzip_header_parser.sv @@
// A transaction is registered on input, then parsed from that register; a result,
// if any, is registered and offered on rsp_chan.
// Throughput: one byte per cycle; while a result waits for rsp_chan.ready, parsing
// stalls and the input register holds at most one further byte.
// Reset (synchronous, active high) empties both registers and restarts parsing.
// Depends on gzp_pkg, gzp_req_if, gzp_rsp_if, gzp_core.

module gzip_header_parser #(
   parameter int COUNT_BITS = gzp_pkg::COUNT_BITS_DEF
) (
   input logic        clock,
   input logic        reset,
   gzp_req_if.sink    req_chan,
   gzp_rsp_if.source  rsp_chan
);
   import gzp_pkg::*;

   logic           in_valid_ff, in_valid_in;
   gzp_item_type   in_item_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   gzp_result_type rsp_data_ff;
   logic           advance;
   logic           res_valid;
   gzp_result_type res;

   assign advance        = in_valid_ff & (~rsp_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;

   assign in_valid_in  = req_chan.valid | (in_valid_ff & ~advance);
   assign rsp_valid_in = advance ? res_valid : (rsp_valid_ff & ~rsp_chan.ready);

   gzp_core #(.COUNT_BITS(COUNT_BITS)) u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .item       (in_item_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_item_ff.req_type      <= req_chan.req_type;
         in_item_ff.data_byte     <= req_chan.data_byte;
         in_item_ff.first_of_file <= req_chan.first_of_file;
      end
      if (advance && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.is_compressed = rsp_data_ff.is_compressed;
   assign rsp_chan.flags_byte    = rsp_data_ff.flags_byte;
   assign rsp_chan.header_length = rsp_data_ff.header_length;
   assign rsp_chan.error_code    = rsp_data_ff.error_code;

endmodule

@@ hdl/gzp_checker.sv @@
// Port-level checks for the gzip header parser, bound to the top level.
// Depends on gzp_pkg and gzip_header_parser.

module gzp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        is_compressed,
   input logic [7:0]  flags_byte,
   input logic [31:0] header_length,
   input logic [4:0]  error_code
);
   import gzp_pkg::*;

   // a stalled result transaction stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(error_code) && $stable(header_length)
                                  && $stable(is_compressed) && $stable(flags_byte))
      else $error("result payload changed while stalled");

   // error results carry no header length and are never compressed
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && error_code != ERR_NONE |-> !is_compressed && header_length == 32'd0)
      else $error("error result with header data");

   // a good header is at least the fixed ten bytes long
   a_ok_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && is_compressed |->
         error_code == ERR_NONE && header_length >= 32'(MIN_HDR_LEN))
      else $error("compressed result malformed");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> error_code <= ERR_MAX && (is_compressed || error_code != ERR_NONE))
      else $error("result code out of range");

endmodule

bind gzip_header_parser gzp_checker u_gzp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .is_compressed (rsp_chan.is_compressed),
   .flags_byte    (rsp_chan.flags_byte),
   .header_length (rsp_chan.header_length),
   .error_code    (rsp_chan.error_code)
);

@@ bench/tb_gzip_header_parser.sv @@
// Self-checking testbench for gzip_header_parser: queued byte streams, a
// clocked driver and monitor, and an in-bench header predictor.
// Depends on gzp_pkg, gzp_req_if, gzp_rsp_if and the parser RTL.
`timescale 1ns / 100ps

module tb_gzip_header_parser;
   import gzp_pkg::*;

   localparam int COUNT_BITS = 32;
   localparam logic [63:0] COUNT_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - COUNT_BITS);
   localparam logic REQ_DATA = 1'b0;
   localparam logic REQ_EOF  = 1'b1;
   localparam int PHASE_ITEMS = 310;

   logic clock = 1'b0;
   logic reset = 1'b1;

   gzp_req_if req_chan ();
   gzp_rsp_if rsp_chan ();

   gzip_header_parser #(.COUNT_BITS(COUNT_BITS)) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   gzp_item_type   pending_items[$];
   gzp_result_type expected_headers[$];
   logic [7:0]     header_bytes[$];
   int             queued_count = 0;
   int             mismatch_count = 0;
   int             send_idle_pct = 0;
   int             recv_stall_pct = 0;

   // predictor state
   logic [PHASE_BITS-1:0] parse_phase = PH_MAGIC1;
   logic [7:0]            flag_bits = 8'h00;
   logic [15:0]           extra_remaining = 16'h0000;
   logic [63:0]           bytes_seen = 64'd0;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = REQ_DATA;
      req_chan.data_byte = 8'h00;
      req_chan.first_of_file = 1'b0;
      rsp_chan.ready = 1'b0;
   end

   function automatic logic [PHASE_BITS-1:0] section_after(input logic [PHASE_BITS-1:0] from);
      if (from <= PH_XLEN1 && flag_bits[FLG_EXTRA]) return PH_XLEN1;
      if (from <= PH_NAME && flag_bits[FLG_NAME]) return PH_NAME;
      if (from <= PH_COMMENT && flag_bits[FLG_COMMENT]) return PH_COMMENT;
      if (from <= PH_CRC1 && flag_bits[FLG_HCRC]) return PH_CRC1;
      return PH_DONE;
   endfunction

   function automatic logic [ERR_BITS-1:0] ERR_ERR_OFFSET(input logic [PHASE_BITS-1:0] ph);
      return ERR_EOF_FLAGS + ERR_BITS'(ph - PH_FLAGS);
   endfunction

   function automatic logic [ERR_BITS-1:0] end_mark_error(input logic [PHASE_BITS-1:0] ph);
      if (ph == PH_MAGIC1) return ERR_EOF_MAGIC1;
      if (ph == PH_MAGIC2) return ERR_EOF_MAGIC2;
      if (ph == PH_METHOD) return ERR_EOF_METHOD;
      // from the flag byte on, end-of-file codes run in phase order
      return ERR_ERR_OFFSET(ph);
   endfunction

   function automatic void finish_header(input logic comp, input logic [63:0] len,
                                         input logic [ERR_BITS-1:0] code);
      gzp_result_type res;
      res.is_compressed = comp;
      res.flags_byte    = flag_bits;
      res.header_length = (len > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : len[31:0];
      res.error_code    = code;
      expected_headers.push_back(res);
      parse_phase = PH_DONE;
   endfunction

   function automatic void parse_item(input gzp_item_type it);
      logic [PHASE_BITS-1:0] nxt;
      logic [7:0]            b;
      b = it.data_byte;
      if (it.first_of_file) begin
         parse_phase = PH_MAGIC1;
         flag_bits = 8'h00;
         extra_remaining = 16'h0000;
         bytes_seen = 64'd0;
      end
      if (parse_phase >= PH_DONE) return;
      if (it.req_type == REQ_EOF) begin
         finish_header(1'b0, 64'd0, end_mark_error(parse_phase));
         return;
      end
      if (bytes_seen < COUNT_LIMIT) bytes_seen++;
      nxt = parse_phase + 1'b1;
      case (parse_phase)
         PH_MAGIC1: if (b != MAGIC1_BYTE) begin
            finish_header(1'b0, 64'd0, ERR_BAD_MAGIC1);
            return;
         end
         PH_MAGIC2: if (b != MAGIC2_BYTE) begin
            finish_header(1'b0, 64'd0, ERR_BAD_MAGIC2);
            return;
         end
         PH_METHOD: if (b != METHOD_BYTE) begin
            finish_header(1'b0, 64'd0, ERR_BAD_METHOD);
            return;
         end
         PH_FLAGS: flag_bits = b;
         PH_OS: nxt = section_after(PH_XLEN1);
         PH_XLEN1: extra_remaining = {8'h00, b};
         PH_XLEN2: begin
            extra_remaining[15:8] = b;
            nxt = (extra_remaining != 0) ? PH_XDATA : section_after(PH_NAME);
         end
         PH_XDATA: begin
            extra_remaining = extra_remaining - 1'b1;
            nxt = (extra_remaining != 0) ? PH_XDATA : section_after(PH_NAME);
         end
         PH_NAME: nxt = (b != 0) ? PH_NAME : section_after(PH_COMMENT);
         PH_COMMENT: nxt = (b != 0) ? PH_COMMENT : section_after(PH_CRC1);
         PH_CRC2: nxt = PH_DONE;
         default: ;
      endcase
      if (nxt >= PH_DONE) finish_header(1'b1, bytes_seen, ERR_NONE);
      else parse_phase = nxt;
   endfunction

   // driver: predicts each accepted transaction, then offers the next one
   always @(posedge clock) begin : drive_bytes
      gzp_item_type next_item;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            parse_item({req_chan.req_type, req_chan.data_byte, req_chan.first_of_file});
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               next_item = pending_items.pop_front();
               req_chan.valid         <= 1'b1;
               req_chan.req_type      <= next_item.req_type;
               req_chan.data_byte     <= next_item.data_byte;
               req_chan.first_of_file <= next_item.first_of_file;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : check_headers
      gzp_result_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_headers.size() == 0) begin
            $display({"%0t: unexpected result, expected none, ",
                      "got comp=%0b flags=%0h len=%0h err=%0d"},
                     $time, rsp_chan.is_compressed, rsp_chan.flags_byte,
                     rsp_chan.header_length, rsp_chan.error_code);
            mismatch_count++;
         end else begin
            want = expected_headers.pop_front();
            check_field("is_compressed", 32'(want.is_compressed),
                        32'(rsp_chan.is_compressed));
            check_field("flags_byte", 32'(want.flags_byte), 32'(rsp_chan.flags_byte));
            check_field("header_length", want.header_length, rsp_chan.header_length);
            check_field("error_code", 32'(want.error_code), 32'(rsp_chan.error_code));
         end
      end
   end

   task automatic queue_item(input logic kind, input logic [7:0] b, input logic first);
      gzp_item_type it;
      it.req_type = kind;
      it.data_byte = b;
      it.first_of_file = first;
      pending_items.push_back(it);
      queued_count++;
   endtask

   task automatic build_header(input logic [7:0] flg, input int xlen, input int name_len,
                               input int comment_len);
      header_bytes.delete();
      header_bytes.push_back(MAGIC1_BYTE);
      header_bytes.push_back(MAGIC2_BYTE);
      header_bytes.push_back(METHOD_BYTE);
      header_bytes.push_back(flg);
      repeat (6) header_bytes.push_back(8'($urandom));    // mtime, xfl, os
      if (flg[FLG_EXTRA]) begin
         header_bytes.push_back(xlen[7:0]);
         header_bytes.push_back(xlen[15:8]);
         repeat (xlen) header_bytes.push_back(8'($urandom));
      end
      if (flg[FLG_NAME]) begin
         repeat (name_len) header_bytes.push_back(8'($urandom_range(255, 1)));
         header_bytes.push_back(8'h00);
      end
      if (flg[FLG_COMMENT]) begin
         repeat (comment_len) header_bytes.push_back(8'($urandom_range(255, 1)));
         header_bytes.push_back(8'h00);
      end
      if (flg[FLG_HCRC]) repeat (2) header_bytes.push_back(8'($urandom));
   endtask

   // sends the first stop_at header bytes, an optional end mark, then noise
   task automatic queue_file(input int stop_at, input bit end_mark, input bit restart,
                             input int trail);
      logic lead;
      lead = restart;
      for (int i = 0; i < stop_at && i < header_bytes.size(); i++) begin
         queue_item(REQ_DATA, header_bytes[i], lead);
         lead = 1'b0;
      end
      if (end_mark) queue_item(REQ_EOF, 8'($urandom), lead);
      repeat (trail) queue_item(1'($urandom), 8'($urandom), $urandom_range(15) == 0);
   endtask

   task automatic queue_random_file();
      logic [7:0] flg;
      int         xlen;
      int         pick;
      flg = 8'($urandom);
      pick = $urandom_range(24);
      if (pick < 20) xlen = $urandom_range(5);
      else if (pick < 24) xlen = $urandom_range(255);
      else xlen = 256 + $urandom_range(63);
      build_header(flg, xlen, $urandom_range(6), $urandom_range(6));
      pick = $urandom_range(99);
      if (pick < 60) begin
         queue_file(header_bytes.size(), $urandom_range(3) == 0, 1'b1, $urandom_range(3));
      end else if (pick < 85) begin
         queue_file($urandom_range(header_bytes.size() - 1), 1'b1, 1'b1, $urandom_range(2));
      end else if (pick < 93) begin
         header_bytes[$urandom_range(2)] = 8'($urandom);
         queue_file(header_bytes.size(), 1'b0, 1'b1, 1);
      end else begin
         // dropped mid-header, the next file restarts it
         queue_file($urandom_range(header_bytes.size() - 1, 1), 1'b0, 1'b1, 0);
      end
   endtask

   initial begin : stimulus
      int stop_count;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // first file after reset, no first_of_file on its opening byte
      build_header(8'h00, 0, 0, 0);
      queue_file(header_bytes.size(), 1'b0, 1'b0, 0);
      // every flag bit set, reserved ones too; trailing items are ignored
      build_header(8'hFF, 3, 2, 2);
      queue_file(header_bytes.size(), 1'b1, 1'b1, 3);
      // end mark in each header field in turn
      for (int p = 0; p < 20; p++) begin
         build_header(8'h1E, 2, 1, 1);
         queue_file(p, 1'b1, 1'b1, 0);
      end
      // bad magic bytes and bad method
      for (int k = 0; k < 6; k++) begin
         build_header(8'h00, 0, 0, 0);
         case (k)
            0: header_bytes[0] = 8'h00;
            1: header_bytes[0] = 8'hFF;
            2: header_bytes[1] = 8'h8A;
            3: header_bytes[1] = 8'h0B;
            4: header_bytes[2] = 8'h07;
            default: header_bytes[2] = 8'hF7;
         endcase
         queue_file(header_bytes.size(), 1'b0, 1'b1, 0);
      end
      // empty extra field
      build_header(8'h04, 0, 0, 0);
      queue_file(header_bytes.size(), 1'b0, 1'b1, 0);
      // restart in the middle of a name
      build_header(8'h08, 0, 4, 0);
      queue_file(12, 1'b0, 1'b1, 0);
      // end mark as a restart item, data byte to be ignored
      queue_item(REQ_EOF, 8'hFF, 1'b1);
      build_header(8'h0C, 256, 3, 0);
      queue_file(header_bytes.size(), 1'b0, 1'b1, 0);

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
            default: begin send_idle_pct = 31; recv_stall_pct = 31; end
         endcase
         stop_count = queued_count + PHASE_ITEMS;
         while (queued_count < stop_count) queue_random_file();
         while (pending_items.size() != 0) @(negedge clock);
      end

      while (req_chan.valid) @(negedge clock);
      while (expected_headers.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("timeout, %0d results still expected", expected_headers.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule
